// ===== rtl/rau_pkg.sv =====
// rational arithmetic unit: shared types and constants
// command codes, sequencer states and fixed port field widths; no dependencies
`timescale 1ns / 1ps

package rau_pkg;

  // fixed field widths of the stream ports
  localparam int FIELD_W   = 32;
  localparam int CMD_W     = 4;
  localparam int IN_DATA_W = 4 * FIELD_W;
  localparam int OUT_DATA_W = 2 * FIELD_W;
  localparam int OUT_USER_W = 2;

  // command codes carried in in_tuser
  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 4'd0,
    CMD_SUB    = 4'd1,
    CMD_MUL    = 4'd2,
    CMD_DIV    = 4'd3,
    CMD_GT     = 4'd4,
    CMD_LT     = 4'd5,
    CMD_EQ     = 4'd6,
    CMD_GE     = 4'd7,
    CMD_LE     = 4'd8,
    CMD_REDUCE = 4'd9
  } cmd_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_RED,
    S_GCD,
    S_DIVN,
    S_DIVD,
    S_OUT
  } state_t;

endpackage

// ===== rtl/rau_mul.sv =====
// rational arithmetic unit: signed multiplier with registered product
// one WIDTH x WIDTH product per cycle; uses rau_pkg
`timescale 1ns / 1ps

module rau_mul
  import rau_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic                       clk,
  input  logic signed [WIDTH-1:0]    mul_a,
  input  logic signed [WIDTH-1:0]    mul_b,
  output logic signed [2*WIDTH-1:0]  prod_r
);

  logic signed [2*WIDTH-1:0] prod_nxt;

  assign prod_nxt = (2*WIDTH)'(mul_a) * (2*WIDTH)'(mul_b);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

// ===== rtl/rau_div.sv =====
// rational arithmetic unit: unsigned restoring divider, one quotient bit a cycle
// done is a one-cycle pulse; uses rau_pkg
`timescale 1ns / 1ps

module rau_div
  import rau_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [WIDTH-1:0]  dividend,
  input  logic [WIDTH-1:0]  divisor,
  output logic              done,
  output logic [WIDTH-1:0]  quotient
);

  localparam int CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] quo_r, quo_nxt;
  logic [WIDTH-1:0] rem_r, rem_nxt;
  logic [WIDTH-1:0] dsr_r, dsr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   diff;

  assign shifted = {rem_r, quo_r[WIDTH-1]};
  assign diff    = shifted - {1'b0, dsr_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      cnt_nxt  = CW'(WIDTH);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // trial subtract, keep the difference when it does not borrow
      if (shifted >= {1'b0, dsr_r}) begin
        rem_nxt = diff[WIDTH-1:0];
        quo_nxt = {quo_r[WIDTH-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[WIDTH-1:0];
        quo_nxt = {quo_r[WIDTH-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== rtl/rau_gcd.sv =====
// rational arithmetic unit: binary gcd of two positive values
// one shift or subtract a cycle, done is a one-cycle pulse; uses rau_pkg
`timescale 1ns / 1ps

module rau_gcd
  import rau_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [WIDTH-1:0]  x,
  input  logic [WIDTH-1:0]  y,
  output logic              done,
  output logic [WIDTH-1:0]  gcd
);

  localparam int KW = $clog2(WIDTH);

  logic [WIDTH-1:0] u_r, u_nxt;
  logic [WIDTH-1:0] v_r, v_nxt;
  logic [KW-1:0]    k_r, k_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  always_comb begin
    u_nxt    = u_r;
    v_nxt    = v_r;
    k_nxt    = k_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      u_nxt    = x;
      v_nxt    = y;
      k_nxt    = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      priority if (u_r == v_r) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else if (!u_r[0] && !v_r[0]) begin
        // common factor of two
        u_nxt = u_r >> 1;
        v_nxt = v_r >> 1;
        k_nxt = k_r + KW'(1);
      end else if (!u_r[0]) begin
        u_nxt = u_r >> 1;
      end else if (!v_r[0]) begin
        v_nxt = v_r >> 1;
      end else if (u_r > v_r) begin
        u_nxt = u_r - v_r;
      end else begin
        v_nxt = v_r - u_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      k_r    <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      k_r    <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    u_r <= u_nxt;
    v_r <= v_nxt;
  end

  assign done = done_r;
  assign gcd  = u_r << k_r;

endmodule

// ===== rtl/rational_arithmetic_unit_top.sv =====
// rational arithmetic unit: top level with the command sequencer
// uses rau_pkg, rau_mul, rau_div and rau_gcd
`timescale 1ns / 1ps

// Takes two signed fractions a = a_num/a_den and b = b_num/b_den and a command
// per input beat and returns one result beat. Add, sub, mul and div form the
// unreduced cross-product fraction, wrapped to WIDTH bits and sign-extended to
// 32 bits on the port. The five comparisons test a_num*b_den against
// b_num*a_den with exact double-width products and return zeros in the
// fraction fields. Reduce divides a by the common divisor of its two parts
// (gcd when both are positive, 1 when the smaller one is zero or negative,
// the value itself when both are equal) and flags error when both are zero.
// Operand fields use only their low WIDTH bits, sign-extended. One item is
// in flight at a time: in_tready is high only when the sequencer is idle,
// and comes back in the cycle after the result beat is taken.
// Arithmetic and compare run three products in turn through the one shared
// multiplier, then offer the result beat. The special cases of reduce offer it
// from S_RED, and unused command codes offer it straight after the input beat.
// A reduce of two positive parts checks the special cases, runs a binary gcd
// of shift or subtract steps, then two divisions on the shared divider,
// numerator first, then denominator, and then offers the result beat.
// Unused command codes return all zeros.

module rational_arithmetic_unit_top
  import rau_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_DATA_W-1:0]   in_tdata,   // a_num, a_den, b_num, b_den
  input  logic [CMD_W-1:0]       in_tuser,   // command
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_DATA_W-1:0]  out_tdata,  // res_num, res_den
  output logic [OUT_USER_W-1:0]  out_tuser   // compare_true, error
);

  state_t state_r, state_nxt;
  cmd_t   cmd_r, cmd_nxt;
  logic   [1:0] step_r, step_nxt;

  // operand registers
  logic signed [WIDTH-1:0] an_r, an_nxt;
  logic signed [WIDTH-1:0] ad_r, ad_nxt;
  logic signed [WIDTH-1:0] bn_r, bn_nxt;
  logic signed [WIDTH-1:0] bd_r, bd_nxt;

  // held products
  logic signed [2*WIDTH-1:0] p0_r, p0_nxt;
  logic signed [2*WIDTH-1:0] p1_r, p1_nxt;

  // result registers
  logic [WIDTH-1:0] rn_r, rn_nxt;
  logic [WIDTH-1:0] rd_r, rd_nxt;
  logic             ct_r, ct_nxt;
  logic             er_r, er_nxt;

  // shared unit hookup
  logic signed [WIDTH-1:0]   mul_a;
  logic signed [WIDTH-1:0]   mul_b;
  logic signed [2*WIDTH-1:0] mul_p;
  logic                      gcd_start;
  logic                      gcd_done;
  logic                      div_start;
  logic                      div_done;
  logic [WIDTH-1:0]          gcd_val;
  logic [WIDTH-1:0]          div_q;
  logic [WIDTH-1:0]          div_dividend;

  logic in_beat;
  logic out_beat;

  assign in_tready = (state_r == S_IDLE);
  assign in_beat   = in_tvalid && in_tready;
  assign out_tvalid = (state_r == S_OUT);
  assign out_beat  = out_tvalid && out_tready;

  // operand selection for the three products in turn
  always_comb begin
    unique case (step_r)
      2'd0: begin
        mul_a = an_r;
        mul_b = (cmd_r == CMD_MUL) ? bn_r : bd_r;
      end
      2'd1: begin
        mul_a = ad_r;
        mul_b = bn_r;
      end
      default: begin
        mul_a = ad_r;
        mul_b = (cmd_r == CMD_DIV) ? bn_r : bd_r;
      end
    endcase
  end

  // the first division is started on leaving the gcd, the second when the first ends
  assign div_dividend = (state_r == S_GCD) ? an_r : ad_r;

  rau_mul #(.WIDTH(WIDTH)) u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (mul_p)
  );

  rau_gcd #(.WIDTH(WIDTH)) u_gcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (gcd_start),
    .x     (an_r),
    .y     (ad_r),
    .done  (gcd_done),
    .gcd   (gcd_val)
  );

  rau_div #(.WIDTH(WIDTH)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (gcd_val),
    .done     (div_done),
    .quotient (div_q)
  );

  // next state and datapath control
  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    step_nxt  = step_r;
    an_nxt    = an_r;
    ad_nxt    = ad_r;
    bn_nxt    = bn_r;
    bd_nxt    = bd_r;
    p0_nxt    = p0_r;
    p1_nxt    = p1_r;
    rn_nxt    = rn_r;
    rd_nxt    = rd_r;
    ct_nxt    = ct_r;
    er_nxt    = er_r;
    gcd_start = 1'b0;
    div_start = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          cmd_nxt  = cmd_t'(in_tuser);
          an_nxt   = in_tdata[WIDTH-1:0];
          ad_nxt   = in_tdata[FIELD_W+WIDTH-1:FIELD_W];
          bn_nxt   = in_tdata[2*FIELD_W+WIDTH-1:2*FIELD_W];
          bd_nxt   = in_tdata[3*FIELD_W+WIDTH-1:3*FIELD_W];
          step_nxt = '0;
          rn_nxt   = '0;
          rd_nxt   = '0;
          ct_nxt   = 1'b0;
          er_nxt   = 1'b0;
          priority if (in_tuser == CMD_REDUCE) begin
            state_nxt = S_RED;
          end else if (in_tuser <= CMD_LE) begin
            state_nxt = S_MUL;
          end else begin
            // unused code: all-zero result
            state_nxt = S_OUT;
          end
        end
      end

      S_MUL: begin
        step_nxt = step_r + 2'd1;
        if (step_r == 2'd1) begin
          p0_nxt = mul_p;
        end
        if (step_r == 2'd2) begin
          p1_nxt = mul_p;
        end
        if (step_r == 2'd3) begin
          // third product is on the multiplier output now
          state_nxt = S_OUT;
          unique case (cmd_r)
            CMD_ADD: begin
              rn_nxt = p0_r[WIDTH-1:0] + p1_r[WIDTH-1:0];
              rd_nxt = mul_p[WIDTH-1:0];
            end
            CMD_SUB: begin
              rn_nxt = p0_r[WIDTH-1:0] - p1_r[WIDTH-1:0];
              rd_nxt = mul_p[WIDTH-1:0];
            end
            CMD_MUL, CMD_DIV: begin
              rn_nxt = p0_r[WIDTH-1:0];
              rd_nxt = mul_p[WIDTH-1:0];
            end
            CMD_GT: ct_nxt = (p0_r > p1_r);
            CMD_LT: ct_nxt = (p0_r < p1_r);
            CMD_EQ: ct_nxt = (p0_r == p1_r);
            CMD_GE: ct_nxt = (p0_r >= p1_r);
            CMD_LE: ct_nxt = (p0_r <= p1_r);
            default: ;
          endcase
        end
      end

      S_RED: begin
        priority if (an_r == ad_r) begin
          state_nxt = S_OUT;
          if (an_r == '0) begin
            er_nxt = 1'b1;
            rn_nxt = an_r;
            rd_nxt = ad_r;
          end else begin
            rn_nxt = WIDTH'(1);
            rd_nxt = WIDTH'(1);
          end
        end else if (an_r[WIDTH-1] || (an_r == '0) || ad_r[WIDTH-1] || (ad_r == '0)) begin
          // smaller part not positive: pass through
          state_nxt = S_OUT;
          rn_nxt    = an_r;
          rd_nxt    = ad_r;
        end else begin
          gcd_start = 1'b1;
          state_nxt = S_GCD;
        end
      end

      S_GCD: begin
        if (gcd_done) begin
          div_start = 1'b1;
          state_nxt = S_DIVN;
        end
      end

      S_DIVN: begin
        if (div_done) begin
          rn_nxt    = div_q;
          div_start = 1'b1;
          state_nxt = S_DIVD;
        end
      end

      S_DIVD: begin
        if (div_done) begin
          rd_nxt    = div_q;
          state_nxt = S_OUT;
        end
      end

      S_OUT: begin
        if (out_beat) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    an_r  <= an_nxt;
    ad_r  <= ad_nxt;
    bn_r  <= bn_nxt;
    bd_r  <= bd_nxt;
    p0_r  <= p0_nxt;
    p1_r  <= p1_nxt;
    rn_r  <= rn_nxt;
    rd_r  <= rd_nxt;
    ct_r  <= ct_nxt;
    er_r  <= er_nxt;
  end

  // sign-extend the WIDTH-bit results to the port fields
  assign out_tdata = {FIELD_W'($signed(rd_r)), FIELD_W'($signed(rn_r))};
  assign out_tuser = {er_r, ct_r};

endmodule

// ===== bench/tb_top.sv =====
// self-checking bench for rational_arithmetic_unit_top: stream stimulus, in-bench predictor
// depends on rau_pkg and the rtl top level only
`timescale 1ns / 1ps

module tb_top;
  import rau_pkg::*;

  localparam int W           = 32;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int DRAIN_WAIT  = 200;

  // codes the unit does not define, they must come back as all zeros
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 4'd10;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 4'd15;

  localparam logic [FIELD_W-1:0] F_MAX  = 32'h7fff_ffff;
  localparam logic [FIELD_W-1:0] F_MIN  = 32'h8000_0000;
  localparam logic [FIELD_W-1:0] F_NEG1 = 32'hffff_ffff;
  // consecutive fibonacci numbers, longest gcd chain below 2^31
  localparam logic [FIELD_W-1:0] F_FIB_HI = 32'd1836311903;
  localparam logic [FIELD_W-1:0] F_FIB_LO = 32'd1134903170;

  typedef struct packed {
    logic [FIELD_W-1:0] num;
    logic [FIELD_W-1:0] den;
    logic               cmp;
    logic               err;
  } frac_result_t;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;    // a_num, a_den, b_num, b_den
  logic [CMD_W-1:0]      in_tuser   = '0;    // command
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;          // res_num, res_den
  logic [OUT_USER_W-1:0] out_tuser;          // compare_true, error

  frac_result_t pending_results[$];
  frac_result_t oldest;
  bit           idle_on    = 1'b1;
  int           sink_hold  = 0;
  int           beats_sent = 0;
  int           beats_checked = 0;
  int           reduce_beats  = 0;
  int           fail_cnt   = 0;
  int           cycle_cnt  = 0;

  rational_arithmetic_unit_top #(.WIDTH(W)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  // low W bits of v as a signed value
  function automatic longint sext_field(logic [63:0] v);
    longint r;
    r = longint'(v) & ((longint'(1) << W) - 1);
    if (r[W-1]) r = r - (longint'(1) << W);
    return r;
  endfunction

  // wrap to W bits, sign-extended onto the 32-bit port field
  function automatic logic [FIELD_W-1:0] wrap_field(longint v);
    longint s;
    s = sext_field(v);
    return s[FIELD_W-1:0];
  endfunction

  function automatic longint unsigned gcd_of(longint unsigned x, longint unsigned y);
    longint unsigned t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic frac_result_t predict_rational(logic [CMD_W-1:0] cmd,
                                                    logic [FIELD_W-1:0] an_f,
                                                    logic [FIELD_W-1:0] ad_f,
                                                    logic [FIELD_W-1:0] bn_f,
                                                    logic [FIELD_W-1:0] bd_f);
    frac_result_t    r;
    longint          an, ad, bn, bd, p1, p2, lo;
    longint unsigned g;
    r  = '0;
    an = sext_field({32'b0, an_f});
    ad = sext_field({32'b0, ad_f});
    bn = sext_field({32'b0, bn_f});
    bd = sext_field({32'b0, bd_f});
    // exact cross products for the comparisons
    p1 = an * bd;
    p2 = bn * ad;
    case (cmd)
      CMD_ADD: begin
        r.num = wrap_field(an * bd + ad * bn);
        r.den = wrap_field(ad * bd);
      end
      CMD_SUB: begin
        r.num = wrap_field(an * bd - ad * bn);
        r.den = wrap_field(ad * bd);
      end
      CMD_MUL: begin
        r.num = wrap_field(an * bn);
        r.den = wrap_field(ad * bd);
      end
      CMD_DIV: begin
        r.num = wrap_field(an * bd);
        r.den = wrap_field(ad * bn);
      end
      CMD_GT: r.cmp = (p1 >  p2);
      CMD_LT: r.cmp = (p1 <  p2);
      CMD_EQ: r.cmp = (p1 == p2);
      CMD_GE: r.cmp = (p1 >= p2);
      CMD_LE: r.cmp = (p1 <= p2);
      CMD_REDUCE: begin
        if (an == ad) begin
          if (an == 0) begin
            // both zero: flagged, fraction passes through
            r.err = 1'b1;
            r.num = wrap_field(an);
            r.den = wrap_field(ad);
          end else begin
            r.num = 1;
            r.den = 1;
          end
        end else begin
          lo = (an < ad) ? an : ad;
          if (lo <= 0) begin
            r.num = wrap_field(an);
            r.den = wrap_field(ad);
          end else begin
            g     = gcd_of(an, ad);
            r.num = wrap_field(longint'(an / g));
            r.den = wrap_field(longint'(ad / g));
          end
        end
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------- idling

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 15);
    if (r < 12) return $urandom_range(0, 3);
    if (r < 15) return $urandom_range(4, 12);
    return $urandom_range(30, 150);
  endfunction

  // result side back-pressure
  always @(posedge clk) begin
    if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
    end else if (idle_on && out_tready && $urandom_range(0, 3) == 0) begin
      out_tready <= 1'b0;
      sink_hold  <= pick_gap();
    end else begin
      out_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- driver

  task automatic send_item(logic [CMD_W-1:0] cmd, logic [FIELD_W-1:0] an,
                           logic [FIELD_W-1:0] ad, logic [FIELD_W-1:0] bn,
                           logic [FIELD_W-1:0] bd);
    int gap;
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {bd, bn, ad, an};
    in_tuser  <= cmd;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(predict_rational(cmd, an, ad, bn, bd));
    beats_sent++;
    if (cmd == CMD_REDUCE) reduce_beats++;
  endtask

  // ---------------------------------------------------------------- checker

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no result pending");
        fail_cnt++;
      end else begin
        oldest = pending_results.pop_front();
        beats_checked++;
        if (out_tdata[FIELD_W-1:0] !== oldest.num) begin
          $error("res_num mismatch: expected %0d, got %0d",
                 $signed(oldest.num), $signed(out_tdata[FIELD_W-1:0]));
          fail_cnt++;
        end
        if (out_tdata[2*FIELD_W-1:FIELD_W] !== oldest.den) begin
          $error("res_den mismatch: expected %0d, got %0d",
                 $signed(oldest.den), $signed(out_tdata[2*FIELD_W-1:FIELD_W]));
          fail_cnt++;
        end
        if (out_tuser[0] !== oldest.cmp) begin
          $error("compare_true mismatch: expected %0b, got %0b", oldest.cmp, out_tuser[0]);
          fail_cnt++;
        end
        if (out_tuser[1] !== oldest.err) begin
          $error("error mismatch: expected %0b, got %0b", oldest.err, out_tuser[1]);
          fail_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- operands

  function automatic logic [FIELD_W-1:0] rand_operand();
    int s;
    logic [FIELD_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom();
      4, 5, 6: begin
        s = $urandom_range(0, 40);
        return FIELD_W'(s - 20);
      end
      7: begin
        case ($urandom_range(0, 4))
          0: return '0;
          1: return 32'd1;
          2: return F_NEG1;
          3: return F_MAX;
          default: return F_MIN;
        endcase
      end
      8: return $urandom() >> $urandom_range(0, 31);
      default: begin
        v = $urandom() >> $urandom_range(0, 31);
        return -v;
      end
    endcase
  endfunction

  // mostly positive pairs with a shared factor so the gcd loop does real work
  task automatic gen_reduce_pair(output logic [FIELD_W-1:0] an, output logic [FIELD_W-1:0] ad);
    int unsigned g;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        g  = $urandom_range(1, 2000);
        an = g * $urandom_range(1, 1_000_000);
        ad = g * $urandom_range(1, 1_000_000);
      end
      6: begin
        an = rand_operand();
        ad = an;
      end
      7: begin
        an = rand_operand();
        ad = ($urandom_range(0, 1) != 0) ? '0 : -FIELD_W'($urandom_range(1, 1000));
        if ($urandom_range(0, 1) != 0) {an, ad} = {ad, an};
      end
      8: begin
        an = $urandom();
        ad = $urandom();
      end
      default: begin
        an = $urandom() & F_MAX;
        ad = $urandom() & F_MAX;
        if ($urandom_range(0, 3) == 0) {an, ad} = {F_FIB_HI, F_FIB_LO};
      end
    endcase
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_directed_arith();
    send_item(CMD_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
    send_item(CMD_ADD, '0, '0, '0, '0);
    send_item(CMD_SUB, F_MIN, 32'd1, F_MAX, 32'd1);
    send_item(CMD_SUB, F_NEG1, F_NEG1, F_NEG1, F_NEG1);
    send_item(CMD_MUL, F_MAX, F_MAX, F_MAX, F_MAX);
    send_item(CMD_MUL, F_MIN, F_NEG1, F_NEG1, F_MIN);
    send_item(CMD_DIV, 32'd3, 32'd4, '0, 32'd5);
    send_item(CMD_DIV, F_MIN, F_MAX, F_MIN, F_MAX);
  endtask

  task automatic test_directed_compare();
    send_item(CMD_GT, 32'd1, 32'd2, 32'd1, 32'd3);
    send_item(CMD_LT, 32'd1, 32'd3, 32'd1, 32'd2);
    send_item(CMD_EQ, 32'd2, 32'd4, 32'd1, 32'd2);
    send_item(CMD_GE, 32'd5, 32'd7, 32'd5, 32'd7);
    send_item(CMD_LE, 32'd1, F_NEG1, 32'd1, 32'd2);
    // cross products beyond 32 bits
    send_item(CMD_GT, F_MIN, 32'd1, F_MAX, F_MIN);
    send_item(CMD_LT, F_MAX, F_MIN, F_MIN, F_MAX);
  endtask

  task automatic test_directed_reduce();
    send_item(CMD_REDUCE, 32'd84, 32'd36, $urandom(), $urandom());
    send_item(CMD_REDUCE, 32'd7, 32'd9, '0, '0);
    send_item(CMD_REDUCE, F_FIB_HI, F_FIB_LO, F_MAX, F_MAX);
    send_item(CMD_REDUCE, F_MAX, F_MAX - 1, F_MIN, F_MIN);
    // equal values, nonzero, come back as 1/1
    send_item(CMD_REDUCE, -FIELD_W'(6), -FIELD_W'(6), '0, '0);
    send_item(CMD_REDUCE, F_MIN, F_MIN, '0, '0);
    // smaller value zero or negative: fraction unchanged
    send_item(CMD_REDUCE, 32'd5, '0, '0, '0);
    send_item(CMD_REDUCE, 32'd12, -FIELD_W'(8), '0, '0);
    // both zero raises the error flag
    send_item(CMD_REDUCE, '0, '0, F_NEG1, F_NEG1);
    send_item(CMD_SPARE_LO, 32'd3, 32'd4, 32'd5, 32'd6);
    send_item(CMD_SPARE_HI, F_NEG1, F_NEG1, F_NEG1, F_NEG1);
  endtask

  task automatic test_random_arith_compare(int count);
    repeat (count) begin
      send_item(CMD_W'($urandom_range(int'(CMD_ADD), int'(CMD_LE))),
                rand_operand(), rand_operand(), rand_operand(), rand_operand());
    end
  endtask

  task automatic test_random_reduce(int count);
    logic [FIELD_W-1:0] an, ad;
    repeat (count) begin
      gen_reduce_pair(an, ad);
      send_item(CMD_REDUCE, an, ad, $urandom(), $urandom());
    end
  endtask

  // back-to-back traffic with no gaps on either side
  task automatic test_no_idle_mix(int count);
    logic [FIELD_W-1:0] an, ad;
    idle_on = 1'b0;
    repeat (count) begin
      if ($urandom_range(0, 2) == 0) begin
        gen_reduce_pair(an, ad);
        send_item(CMD_REDUCE, an, ad, $urandom(), $urandom());
      end else begin
        send_item(CMD_W'($urandom_range(int'(CMD_ADD), int'(CMD_LE))),
                  rand_operand(), rand_operand(), rand_operand(), rand_operand());
      end
    end
    idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles", cycle_cnt);
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_directed_arith();
    test_directed_compare();
    test_directed_reduce();
    test_random_arith_compare(600);
    test_random_reduce(600);
    test_no_idle_mix(150);

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("sent %0d beats (%0d reduce), checked %0d results in %0d cycles",
             beats_sent, reduce_beats, beats_checked, cycle_cnt);
    $display("arith, compare, reduce and spare codes under random source and sink gaps");
    if (fail_cnt == 0 && pending_results.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
